// ===== rtl/core/cma_pkg.sv =====
// Shared constants and handshake types for the circular moving average block.
// Used by the divider and the top level; depends on nothing.
package cma_pkg;

    // Field widths.
    localparam int SAMPLE_W    = 16;
    localparam int WIDTH_W     = 6;
    localparam int HALF_W      = WIDTH_W - 1;
    localparam int SUM_W       = SAMPLE_W + WIDTH_W;

    // Default profile depth and reset value of the window width register.
    localparam int               MAX_LEN_DEF = 64;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd3;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [WIDTH_W-1:0] divisor;
    } t_div_req;

    // Status of the shared divider.
    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/core/cma_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cma_pkg for widths and the request and status types.
module cma_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cma_pkg::t_div_req i_req,
    output cma_pkg::t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(cma_pkg::SUM_W);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [cma_pkg::SUM_W-1:0]   r_quo;
    logic [cma_pkg::WIDTH_W-1:0] r_rem;
    logic [cma_pkg::WIDTH_W-1:0] r_div;

    logic [cma_pkg::WIDTH_W:0]   w_trial;
    logic                        w_ge;
    logic [cma_pkg::WIDTH_W-1:0] w_rem_next;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        w_trial    = {r_rem, r_quo[cma_pkg::SUM_W-1]};
        w_ge       = (w_trial >= {1'b0, r_div});
        w_rem_next = w_ge ? cma_pkg::WIDTH_W'(w_trial - {1'b0, r_div})
                          : cma_pkg::WIDTH_W'(w_trial);
    end

    // Step sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[cma_pkg::SUM_W-2:0], w_ge};
            if (r_step == STEP_W'(cma_pkg::SUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // The quotient never exceeds the sample range, so the low bits carry it.
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[cma_pkg::SAMPLE_W-1:0];

endmodule

// ===== rtl/core/circular_moving_average_unit.sv =====
// Circular boxcar moving average: a sample store, a small sequencer and one shared divider.
// Samples are stored in order while loading. After the last sample, the half width is reduced
// modulo the length; then each result takes one store read per window term, then 22
// divider steps. The next profile may start loading while the final result waits to be
// taken. Reset (synchronous, active low) clears the fill count, the output valid and sets
// window_width to 3; store contents stay.
module circular_moving_average_unit #(
    parameter int MAX_LEN = cma_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel: window_width.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cma_pkg::WIDTH_W-1:0]   i_cfg_data,
    // Sample stream. tdata[15:0] = sample; tlast = last_in.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [cma_pkg::SAMPLE_W-1:0]  i_s_axis_tdata,
    input  logic                          i_s_axis_tlast,
    // Result stream. tdata[15:0] = average; tlast = last_out.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [cma_pkg::SAMPLE_W-1:0]  o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = CW + 1;
    localparam int MW = (CW > cma_pkg::HALF_W) ? CW : cma_pkg::HALF_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MOD,
        S_START,
        S_ACC,
        S_DIV
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_len;
    logic [CW-1:0]                  r_pos;
    logic [cma_pkg::WIDTH_W-1:0]    r_width;
    logic [cma_pkg::HALF_W-1:0]     r_hmod;
    logic [cma_pkg::WIDTH_W-1:0]    r_span;
    logic [cma_pkg::WIDTH_W-1:0]    r_iss;
    logic [AW-1:0]                  r_idx;
    logic                           r_dv;
    logic [cma_pkg::SUM_W-1:0]      r_sum;
    logic                           r_ovalid;
    logic [cma_pkg::SAMPLE_W-1:0]   r_odata;
    logic                           r_olast;
    logic [cma_pkg::SAMPLE_W-1:0]   r_rdata;
    logic [cma_pkg::SAMPLE_W-1:0]   r_store [MAX_LEN];

    logic                           w_full;
    logic                           w_load;
    logic                           w_rd_en;
    logic                           w_at_end;
    logic                           w_idx_wrap;
    logic                           w_emit;
    logic [SW-1:0]                  w_tmp;
    logic [SW-1:0]                  w_start_full;
    logic [AW-1:0]                  w_start;
    cma_pkg::t_div_req              w_div_req;
    cma_pkg::t_div_rsp              w_div_rsp;

    // Handshake and sequencing conditions.
    always_comb begin
        w_full     = (r_count == CW'(MAX_LEN));
        w_load     = (r_state == S_LOAD) && i_s_axis_tvalid;
        w_rd_en    = (r_state == S_ACC) && (r_iss != r_span);
        w_at_end   = ((r_pos + CW'(1)) == r_len);
        w_idx_wrap = ((CW'(r_idx) + CW'(1)) == r_len);
        w_emit     = (r_state == S_DIV) && w_div_rsp.done && (!r_ovalid || i_m_axis_tready);
    end

    // First window index: (pos + len - half mod len) mod len, one compare and subtract.
    always_comb begin
        w_tmp        = SW'(r_pos) + SW'(r_len) - SW'(r_hmod);
        w_start_full = (w_tmp >= SW'(r_len)) ? (w_tmp - SW'(r_len)) : w_tmp;
        w_start      = w_start_full[AW-1:0];
    end

    // Divider request once the window sum is complete.
    always_comb begin
        w_div_req.start    = (r_state == S_ACC) && !w_rd_en && !r_dv;
        w_div_req.dividend = r_sum;
        w_div_req.divisor  = r_span;
    end

    cma_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sample store: written while loading, read one term per cycle while summing.
    always_ff @(posedge i_clk) begin
        if (w_load && !w_full) begin
            r_store[r_count[AW-1:0]] <= i_s_axis_tdata;
        end
        if (w_rd_en) begin
            r_rdata <= r_store[r_idx];
        end
    end

    // Sequencer, configuration register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_width  <= cma_pkg::WIDTH_RESET;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            if (r_ovalid && i_m_axis_tready && !w_emit) begin
                r_ovalid <= 1'b0;
            end
            r_dv <= w_rd_en;

            case (r_state)
                S_LOAD: begin
                    if (i_s_axis_tvalid) begin
                        if (!w_full) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_s_axis_tlast) begin
                            r_len   <= w_full ? r_count : (r_count + CW'(1));
                            r_hmod  <= r_width[cma_pkg::WIDTH_W-1:1];
                            r_span  <= {r_width[cma_pkg::WIDTH_W-1:1], 1'b1};
                            r_pos   <= '0;
                            r_state <= S_MOD;
                        end
                    end
                end
                // Reduce the half width modulo the profile length.
                S_MOD: begin
                    if (MW'(r_hmod) >= MW'(r_len)) begin
                        r_hmod <= r_hmod - cma_pkg::HALF_W'(r_len);
                    end else begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_idx   <= w_start;
                    r_iss   <= '0;
                    r_sum   <= '0;
                    r_state <= S_ACC;
                end
                // Issue reads with wraparound and add the returning data.
                S_ACC: begin
                    if (w_rd_en) begin
                        r_iss <= r_iss + cma_pkg::WIDTH_W'(1);
                        r_idx <= w_idx_wrap ? '0 : (r_idx + AW'(1));
                    end
                    if (r_dv) begin
                        r_sum <= r_sum + cma_pkg::SUM_W'(r_rdata);
                    end
                    if (!w_rd_en && !r_dv) begin
                        r_state <= S_DIV;
                    end
                end
                // Hand the mean to the output register once it is free.
                S_DIV: begin
                    if (w_emit) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= w_div_rsp.quotient;
                        r_olast  <= w_at_end;
                        if (w_at_end) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_pos   <= r_pos + CW'(1);
                            r_state <= S_START;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ===== rtl/core/cma_checker.sv =====
// Port-level checks for circular_moving_average_unit, attached by the bind below.
// Depends on cma_pkg for field widths.
module cma_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         i_s_axis_tlast,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [cma_pkg::SAMPLE_W-1:0] o_m_axis_tdata,
    input logic                         o_m_axis_tlast
);

    logic [1:0] r_pend;
    logic       w_in_last;
    logic       w_out_last;

    assign w_in_last  = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;
    assign w_out_last = o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast;

    // Count profiles whose final result has not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_last && !w_out_last) begin
            r_pend <= r_pend + 2'd1;
        end else if (w_out_last && !w_in_last) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // No result is shown in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // Results only appear for a profile that has been closed.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pend != 2'd0))
        else $error("result without a closed profile");

    // Closing a profile starts the averaging pass, so sample requests stop.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_last |=> !o_s_axis_tready && (r_pend != 2'd3))
        else $error("sample request taken during averaging");

endmodule

bind circular_moving_average_unit cma_checker u_cma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== tb/sv/cma_avg_checker.sv =====
// Checker for the circular moving average block: watches the configuration, sample and
// result channels, predicts each window mean and compares it with what the block sends.
// Depends on cma_pkg for field widths and the window width reset value.
module cma_avg_checker #(
    parameter int MAX_LEN = cma_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [cma_pkg::WIDTH_W-1:0]   i_cfg_data,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [cma_pkg::SAMPLE_W-1:0]  i_s_tdata,    // [15:0] sample
    input  logic                          i_s_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [cma_pkg::SAMPLE_W-1:0]  i_m_tdata,    // [15:0] average
    input  logic                          i_m_tlast,
    output int                            o_fail_count,
    output int                            o_pending
);
    import cma_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                last;
    } t_avg_result;

    // Local copy of the profile, the fill count and the window width register.
    logic [SAMPLE_W-1:0] profile_mem [MAX_LEN];
    int                  profile_len;
    logic [WIDTH_W-1:0]  width_q;
    t_avg_result         expected_avgs [$];
    int                  mismatch_count;
    int                  result_index;

    // Truncated mean of the window centered on pos, wrapping around the profile.
    function automatic logic [SAMPLE_W-1:0] boxcar_mean(int pos, int len, int half);
        logic [SUM_W-1:0] acc;
        int               span;
        int               idx;
        span = 2 * half + 1;
        idx  = (pos + len - (half % len)) % len;
        acc  = '0;
        for (int t = 0; t < span; t++) begin
            acc += SUM_W'(profile_mem[idx]);
            idx = (idx + 1) % len;
        end
        return SAMPLE_W'(acc / SUM_W'(span));
    endfunction

    // Stores one sample; the last one of a profile queues one mean per position.
    function automatic void load_sample(logic [SAMPLE_W-1:0] smp, logic is_last);
        t_avg_result r;
        int          half;
        // Samples beyond the store depth are dropped.
        if (profile_len < MAX_LEN) begin
            profile_mem[profile_len] = smp;
            profile_len++;
        end
        if (is_last) begin
            half = int'(width_q) / 2;
            for (int i = 0; i < profile_len; i++) begin
                r.average = boxcar_mean(i, profile_len, half);
                r.last    = (i == profile_len - 1);
                expected_avgs.insert(expected_avgs.size(), r);
            end
            profile_len = 0;
        end
    endfunction

    function automatic void flag_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    // Every channel is sampled at the rising edge where its request is taken.
    always @(posedge i_clk) begin
        t_avg_result got;
        t_avg_result want;
        if (!i_rst_n) begin
            profile_len = 0;
            width_q     = WIDTH_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                width_q = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                load_sample(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                got.average = i_m_tdata;
                got.last    = i_m_tlast;
                if (expected_avgs.size() == 0) begin
                    flag_failure($sformatf("result %0d: unexpected, average %h last %b",
                                           result_index, got.average, got.last));
                end else begin
                    want = expected_avgs.pop_front();
                    if (got.average !== want.average || got.last !== want.last)
                        flag_failure($sformatf(
                            "result %0d: expected average %h last %b, got average %h last %b",
                            result_index, want.average, want.last, got.average, got.last));
                end
                result_index++;
            end
        end
        o_pending    <= expected_avgs.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ===== tb/sv/circular_moving_average_unit_tb.sv =====
// Testbench top for the circular moving average block: clock, reset, sample stimulus,
// result back-pressure and window width writes. Depends on cma_pkg and cma_avg_checker.
module circular_moving_average_unit_tb;
    import cma_pkg::*;

    localparam int LONG_HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES    = 100;
    localparam int DRAIN_LIMIT      = 400000;
    localparam int PHASE_ITEMS      = 7;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [WIDTH_W-1:0]  cfg_data  = WIDTH_RESET;
    logic                s_valid   = 1'b0;
    logic [SAMPLE_W-1:0] s_data    = '0;
    logic                s_last    = 1'b0;
    logic                m_ready   = 1'b1;
    logic                cfg_ready;
    logic                s_ready;
    logic                m_valid;
    logic [SAMPLE_W-1:0] m_data;
    logic                m_last;
    int                  fail_count;
    int                  pending;
    bit                  idle_on   = 1'b0;
    int                  holds_requested;
    int                  holds_served;

    circular_moving_average_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),      // [15:0] sample
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),      // [15:0] average
        .o_m_axis_tlast  (m_last)
    );

    cma_avg_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),         // [15:0] sample
        .i_s_tlast    (s_last),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),         // [15:0] average
        .i_m_tlast    (m_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #80_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, plus a long hold whenever the stimulus asks for one.
    initial begin
        forever begin
            @(posedge clk);
            if (holds_served != holds_requested) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holds_served++;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one sample and returns at the edge where the request is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic is_last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        s_last  <= is_last;
        do @(posedge clk); while (!s_ready);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_profile(input int len);
        for (int k = 0; k < len; k++)
            send_sample(pick_sample(), k == len - 1);
    endtask

    // Stops offering samples and waits until every predicted mean has arrived.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge clk);
            guard++;
        end while (pending != 0 && guard < DRAIN_LIMIT);
    endtask

    // The window width is only changed with the block idle.
    task automatic set_width(input logic [WIDTH_W-1:0] w);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [WIDTH_W-1:0] plan [6];
        int                 phase_items;
        int                 len;
        bit                 paused;
        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed profiles; the first one runs on the reset width.
        send_sample(16'd100, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd7, 1'b1);
        // Width zero: every mean equals its own sample, including a single-sample profile.
        set_width(6'd0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        // Widest window on tiny profiles: samples are counted many times, largest sum.
        set_width(6'd63);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h0001, 1'b1);
        set_width(6'd1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        set_width(6'd2);
        send_sample(16'h1234, 1'b1);
        set_width(6'd5);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd12345, 1'b1);

        // Random profiles over several window widths; the final phase runs without idling.
        plan[0] = 6'd63;
        plan[1] = WIDTH_W'($urandom_range(2, 61));
        plan[2] = 6'd0;
        plan[3] = WIDTH_W'($urandom_range(0, 63));
        plan[4] = 6'd1;
        plan[5] = 6'd62;
        idle_on = 1'b1;
        for (int p = 0; p < 6; p++) begin
            if (p == 5)
                idle_on = 1'b0;
            set_width(plan[p]);
            // Overfilled profile: the extra samples, the last one too, are dropped.
            if (p == 0)
                send_profile(MAX_LEN_DEF + 2);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                len = $urandom_range(1, 12);
                // Hold the results back while samples keep coming, so the input stalls.
                if (p == 1 && phase_items == 0)
                    holds_requested++;
                send_profile(len);
                phase_items += len;
                if (p == 3 && !paused) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
